### sv/fuzz_payload_generator_defines.svh
// Assertion macros shared by the fuzz payload generator checker.
`ifndef FUZZ_PAYLOAD_GENERATOR_DEFINES_SVH
`define FUZZ_PAYLOAD_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off during reset
`define FPG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset
`define FPG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/fpg_pkg.sv
// Package: types, codes and helper functions for the fuzz payload generator.
package fpg_pkg;

    // Strategy mode codes
    typedef logic [2:0] fpg_mode_t;
    localparam fpg_mode_t MODE_RANDOM   = 3'd0;
    localparam fpg_mode_t MODE_BIT_FLIP = 3'd1;
    localparam fpg_mode_t MODE_ZERO     = 3'd2;
    localparam fpg_mode_t MODE_ONES     = 3'd3;
    localparam fpg_mode_t MODE_BOUNDARY = 3'd4;
    localparam fpg_mode_t MODE_WALKING  = 3'd5;

    // Register indexes (register i at byte address 8*i)
    typedef logic [1:0] fpg_reg_idx_t;
    localparam fpg_reg_idx_t REG_STRATEGY = 2'd0;
    localparam fpg_reg_idx_t REG_SEED     = 2'd1;
    localparam fpg_reg_idx_t REG_BASE     = 2'd2;

    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned DATA_W  = 64;
    localparam int unsigned NUM_BYTES = 8;

    // Seed that replaces a zero seed
    localparam logic [31:0] SEED_ZERO_SUBST = 32'h6D2B_79F5;

    // Number of boundary table entries
    localparam logic [5:0] BOUNDARY_LEN = 6'd6;

    // Generator state and pattern position
    typedef struct packed {
        logic [31:0] gen;
        logic [5:0]  pos;
    } fpg_state_t;

    // One xorshift32 step (13, 17, 5)
    function automatic logic [31:0] xorshift32(input logic [31:0] x);
        logic [31:0] a;
        logic [31:0] b;
        a = x ^ (x << 13);
        b = a ^ (a >> 17);
        return b ^ (b << 5);
    endfunction

    // Boundary byte for a table index 0..5
    function automatic logic [7:0] boundary_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'h00;
            3'd1:    v = 8'h01;
            3'd2:    v = 8'h7F;
            3'd3:    v = 8'h80;
            3'd4:    v = 8'hFE;
            default: v = 8'hFF;
        endcase
        return v;
    endfunction

    // pos mod 6 for a 6-bit pos: quotient by reciprocal 43/256, exact below 64
    function automatic logic [2:0] mod6(input logic [5:0] pos);
        logic [11:0] prod;
        logic [3:0]  quo;
        logic [6:0]  rem;
        prod = {6'd0, pos} * 12'd43;
        quo  = prod[11:8];
        rem  = {1'b0, pos} - 7'({3'd0, quo} * 7'd6);
        return rem[2:0];
    endfunction

endpackage

### sv/fpg_pattern.sv
// Pattern logic: builds one payload and the next generator state from the current state.
module fpg_pattern (
    input  fpg_pkg::fpg_mode_t  mode,
    input  logic [63:0]         base,
    input  fpg_pkg::fpg_state_t cur,
    output logic [63:0]         payload,
    output fpg_pkg::fpg_state_t nxt
);

    logic [31:0] steps [0:8];
    logic [2:0]  bnd_idx;

    // Eight chained generator steps for random mode; step 1 also feeds bit flip
    always_comb begin
        steps[0] = cur.gen;
        for (int i = 1; i <= 8; i++) begin
            steps[i] = fpg_pkg::xorshift32(steps[i-1]);
        end
    end

    assign bnd_idx = fpg_pkg::mod6(cur.pos);

    // Payload and state update per mode
    always_comb begin
        payload = base;
        nxt     = cur;
        case (mode)
            fpg_pkg::MODE_RANDOM: begin
                for (int i = 0; i < 8; i++) begin
                    payload[8*i +: 8] = steps[i+1][7:0];
                end
                nxt.gen = steps[8];
            end
            fpg_pkg::MODE_BIT_FLIP: begin
                payload = base ^ (64'd1 << steps[1][5:0]);
                nxt.gen = steps[1];
            end
            fpg_pkg::MODE_ZERO: begin
                payload = '0;
            end
            fpg_pkg::MODE_ONES: begin
                payload = '1;
            end
            fpg_pkg::MODE_BOUNDARY: begin
                payload = {8{fpg_pkg::boundary_byte(bnd_idx)}};
                nxt.pos = ({3'd0, bnd_idx} + 6'd1 == fpg_pkg::BOUNDARY_LEN) ?
                          6'd0 : ({3'd0, bnd_idx} + 6'd1);
            end
            fpg_pkg::MODE_WALKING: begin
                // byte 7 - pos/8 is the inverted upper index bits
                payload = 64'd1 << {~cur.pos[5:3], cur.pos[2:0]};
                nxt.pos = cur.pos + 6'd1;
            end
            default: begin
                // unused modes pass the base through, state unchanged
                payload = base;
            end
        endcase
    end

endmodule

### sv/fuzz_payload_generator.sv
// Top level: fuzz payload generator with APB configuration and valid/ready channels.
// Takes one request word per cycle while s_ready is high and returns one 8-byte
// payload word per request, in the cycle after acceptance, through a single output
// register; a new request is taken whenever that register is empty or being drained
// the same cycle. The cycle time is set by the pattern path between the generator
// state registers and the output register, whose longest leg is eight chained
// xorshift32 steps in random mode. Registers sit at byte addresses 0 (strategy_mode),
// 8 (seed_value) and 16 (base_payload), 64-bit data; any register write reloads the
// generator from the seed (zero seed maps to 0x6D2B79F5) and clears the pattern
// position, as does a request with s_reseed set.
module fuzz_payload_generator (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fpg_pkg::ADDR_W-1:0]  paddr,
    input  logic [fpg_pkg::DATA_W-1:0]  pwdata,
    output logic [fpg_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    // request channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_reseed,
    // payload channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [7:0]                  m_payload_byte_0,
    output logic [7:0]                  m_payload_byte_1,
    output logic [7:0]                  m_payload_byte_2,
    output logic [7:0]                  m_payload_byte_3,
    output logic [7:0]                  m_payload_byte_4,
    output logic [7:0]                  m_payload_byte_5,
    output logic [7:0]                  m_payload_byte_6,
    output logic [7:0]                  m_payload_byte_7
);

    fpg_pkg::fpg_mode_t  mode_reg;
    logic [31:0]         seed_reg;
    logic [63:0]         base_reg;
    fpg_pkg::fpg_state_t state_reg;
    fpg_pkg::fpg_state_t state_next;
    logic                m_valid_reg;
    logic [63:0]         payload_reg;

    fpg_pkg::fpg_state_t reload_state;
    fpg_pkg::fpg_state_t cur_state;
    logic [63:0]         payload_calc;
    fpg_pkg::fpg_reg_idx_t wr_idx;
    logic                wr_en;
    logic                wr_hit;
    logic                accept;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign wr_idx = paddr[4:3];
    assign wr_hit = wr_en && (wr_idx == fpg_pkg::REG_STRATEGY || wr_idx == fpg_pkg::REG_SEED
                              || wr_idx == fpg_pkg::REG_BASE);

    // Register readback
    always_comb begin
        unique case (wr_idx)
            fpg_pkg::REG_STRATEGY: prdata = {61'd0, mode_reg};
            fpg_pkg::REG_SEED:     prdata = {32'd0, seed_reg};
            fpg_pkg::REG_BASE:     prdata = base_reg;
            default:               prdata = '0;
        endcase
    end

    // Generator reload value
    always_comb begin
        reload_state.gen = (seed_reg == 32'd0) ? fpg_pkg::SEED_ZERO_SUBST : seed_reg;
        reload_state.pos = 6'd0;
    end

    assign cur_state = s_reseed ? reload_state : state_reg;
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;

    fpg_pattern u_pattern (
        .mode    (mode_reg),
        .base    (base_reg),
        .cur     (cur_state),
        .payload (payload_calc),
        .nxt     (state_next)
    );

    // Configuration registers and generator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= fpg_pkg::MODE_RANDOM;
            seed_reg      <= '0;
            base_reg      <= '0;
            state_reg.gen <= fpg_pkg::SEED_ZERO_SUBST;
            state_reg.pos <= '0;
        end else if (wr_hit) begin
            unique case (wr_idx)
                fpg_pkg::REG_STRATEGY: mode_reg <= pwdata[2:0];
                fpg_pkg::REG_SEED:     seed_reg <= pwdata[31:0];
                fpg_pkg::REG_BASE:     base_reg <= pwdata;
                default:               ;
            endcase
            // reload from the seed being written when it is the seed register
            state_reg.gen <= (wr_idx == fpg_pkg::REG_SEED) ?
                             ((pwdata[31:0] == 32'd0) ? fpg_pkg::SEED_ZERO_SUBST : pwdata[31:0])
                             : reload_state.gen;
            state_reg.pos <= '0;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    // Output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            payload_reg <= payload_calc;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_payload_byte_0 = payload_reg[7:0];
    assign m_payload_byte_1 = payload_reg[15:8];
    assign m_payload_byte_2 = payload_reg[23:16];
    assign m_payload_byte_3 = payload_reg[31:24];
    assign m_payload_byte_4 = payload_reg[39:32];
    assign m_payload_byte_5 = payload_reg[47:40];
    assign m_payload_byte_6 = payload_reg[55:48];
    assign m_payload_byte_7 = payload_reg[63:56];

endmodule

### sv/fpg_checker.sv
// Port-level checker for the fuzz payload generator, bound to the top level.
`include "fuzz_payload_generator_defines.svh"

module fpg_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        psel,
    input logic                        pready,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [7:0]                  m_payload_byte_0,
    input logic [7:0]                  m_payload_byte_1,
    input logic [7:0]                  m_payload_byte_2,
    input logic [7:0]                  m_payload_byte_3,
    input logic [7:0]                  m_payload_byte_4,
    input logic [7:0]                  m_payload_byte_5,
    input logic [7:0]                  m_payload_byte_6,
    input logic [7:0]                  m_payload_byte_7
);

    // An empty output register always takes a request
    `FPG_ASSERT_NOW(a_ready_when_empty, !m_valid, s_ready, "s_ready low with no word held")

    // Every accepted request shows up as a word the next cycle
    `FPG_ASSERT_NEXT(a_accept_gives_word, s_valid && s_ready, m_valid, "accepted request lost")

    // Config port never stalls
    `FPG_ASSERT_NOW(a_pready_high, psel, pready, "pready dropped")

    // A stalled word stays valid
    `FPG_ASSERT_NEXT(a_hold_valid, m_valid && !m_ready, m_valid, "m_valid dropped while stalled")

    // A stalled word keeps its payload
    `FPG_ASSERT_NEXT(a_hold_payload, m_valid && !m_ready,
        $stable(m_payload_byte_0) && $stable(m_payload_byte_1) &&
        $stable(m_payload_byte_2) && $stable(m_payload_byte_3) &&
        $stable(m_payload_byte_4) && $stable(m_payload_byte_5) &&
        $stable(m_payload_byte_6) && $stable(m_payload_byte_7), "payload changed while stalled")

endmodule

bind fuzz_payload_generator fpg_checker u_fpg_checker (.*);
